[rtl/dqpi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared types and constants of the dq current PI controller.
// ----------------------------------------------------------------------------
package dqpi_pkg;

	// fixed field and register widths
	localparam int GAIN_W     = 16;
	localparam int ACC_W      = 32;
	localparam int MOD_FRAC   = 16;
	localparam int DECAY_FRAC = 16;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	// integrator decay factor, 0.99 in Q0.16
	localparam logic [DECAY_FRAC-1:0] DECAY_NUM = 16'd64880;
	// reset value of the modulation ratio
	localparam logic [GAIN_W-1:0]     MOD_RESET = 16'd37837;

	// register indexes (word address)
	localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
	localparam logic [1:0] REG_MAX_MOD    = 2'd2;

	// input item kinds
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// sequencer steps
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQR,
		ST_UPD,
		ST_OUT
	} state_t;

	// step strobes from sequencer to lanes and limit unit
	typedef struct packed {
		logic load;  // item transfer, capture inputs
		logic mul;   // first products
		logic sqr;   // limit square and magnitude sum
		logic upd;   // integrator update
		logic fin;   // output written to result register
		logic clr;   // current item is a clear item
	} ctrl_t;

endpackage

`default_nettype wire

[rtl/dqpi_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dqpi_lane
// One axis of the regulator: error, integrator with decay and saturation,
// proportional term, output shift and clamp, previous output register.
// ----------------------------------------------------------------------------
module dqpi_lane #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire dqpi_pkg::ctrl_t                 ctrl,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  target,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  measured,
	input  wire logic [dqpi_pkg::GAIN_W-1:0]     prop_gain,
	input  wire logic [dqpi_pkg::GAIN_W-1:0]     integ_gain,
	input  wire logic                            back,
	input  wire logic [SAMPLE_WIDTH-2:0]         lim,
	output logic signed [SAMPLE_WIDTH-1:0]       drive
);

	localparam int E_W    = SAMPLE_WIDTH + 1;
	localparam int PROD_W = E_W + dqpi_pkg::GAIN_W + 1;
	localparam int SUM_W  = ((PROD_W > dqpi_pkg::ACC_W) ? PROD_W : dqpi_pkg::ACC_W) + 1;
	localparam int ACC_W  = dqpi_pkg::ACC_W;
	localparam int DPR_W  = ACC_W + dqpi_pkg::DECAY_FRAC;

	logic signed [E_W-1:0]    err_s1;
	logic signed [PROD_W-1:0] pprod_s2;
	logic signed [PROD_W-1:0] iprod_s2;
	logic [DPR_W-1:0]         dprod_s2;
	logic                     aneg_s2;
	logic signed [ACC_W-1:0]  accum_q;

	logic [ACC_W-1:0]         acc_mag;
	logic [ACC_W-1:0]         dec_mag;
	logic signed [ACC_W-1:0]  acc_decayed;
	logic signed [SUM_W-1:0]  int_sum;
	logic signed [ACC_W-1:0]  acc_sat;
	logic signed [SUM_W-1:0]  pi_sum;
	logic signed [SUM_W-1:0]  pi_shift;
	logic signed [SUM_W-1:0]  lim_pos;
	logic signed [SUM_W-1:0]  lim_neg;
	logic signed [SUM_W-1:0]  pi_clamp;
	logic signed [SAMPLE_WIDTH-1:0] drive_next;

	// error capture at item transfer
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			err_s1 <= E_W'(target) - E_W'(measured);
		end
	end

	// magnitude of the integrator for the decay product
	assign acc_mag = accum_q[ACC_W-1] ? (~accum_q + 1'b1) : accum_q;

	// products: gains times error, decay of the integrator magnitude
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			pprod_s2 <= $signed({1'b0, prop_gain}) * err_s1;
			iprod_s2 <= $signed({1'b0, integ_gain}) * err_s1;
			dprod_s2 <= acc_mag * dqpi_pkg::DECAY_NUM;
			aneg_s2  <= accum_q[ACC_W-1];
		end
	end

	// decayed value, truncated toward zero
	assign dec_mag     = dprod_s2[DPR_W-1:dqpi_pkg::DECAY_FRAC];
	assign acc_decayed = aneg_s2 ? $signed(~dec_mag + 1'b1) : $signed(dec_mag);

	// integrator sum, saturated to 32 bits
	assign int_sum = SUM_W'(accum_q) + SUM_W'(iprod_s2);
	always_comb begin
		if (int_sum[SUM_W-1:ACC_W-1] == '0 || int_sum[SUM_W-1:ACC_W-1] == '1) begin
			acc_sat = int_sum[ACC_W-1:0];
		end else if (int_sum[SUM_W-1]) begin
			acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	// integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
		end else if (ctrl.upd) begin
			if (ctrl.clr) begin
				accum_q <= '0;
			end else if (back) begin
				accum_q <= acc_decayed;
			end else begin
				accum_q <= acc_sat;
			end
		end
	end

	// output: floor shift, then clamp to the limit
	assign pi_sum   = SUM_W'(pprod_s2) + SUM_W'(accum_q);
	assign pi_shift = pi_sum >>> GAIN_FRAC_BITS;
	assign lim_pos  = $signed(SUM_W'({1'b0, lim}));
	assign lim_neg  = -lim_pos;

	always_comb begin
		if (pi_shift > lim_pos) begin
			pi_clamp = lim_pos;
		end else if (pi_shift < lim_neg) begin
			pi_clamp = lim_neg;
		end else begin
			pi_clamp = pi_shift;
		end
	end

	assign drive_next = ctrl.clr ? '0 : pi_clamp[SAMPLE_WIDTH-1:0];

	// previous output, also the result register of this axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive <= '0;
		end else if (ctrl.fin) begin
			drive <= drive_next;
		end
	end

endmodule

`default_nettype wire

[rtl/dqpi_limit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dqpi_limit
// Merge stage: voltage limit from bus and modulation ratio, and the squared
// magnitude test of the previous output vector against it.
// ----------------------------------------------------------------------------
module dqpi_limit #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire                                  clk,
	input  wire dqpi_pkg::ctrl_t                 ctrl,
	input  wire logic [SAMPLE_WIDTH-2:0]         bus_voltage,
	input  wire logic [dqpi_pkg::GAIN_W-1:0]     max_modulation,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  last_d,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  last_q,
	output logic [SAMPLE_WIDTH-2:0]              lim,
	output logic                                 back
);

	localparam int BUS_W = SAMPLE_WIDTH - 1;
	localparam int LPR_W = BUS_W + dqpi_pkg::GAIN_W;
	localparam int SQ_W  = 2 * SAMPLE_WIDTH;
	localparam int LSQ_W = 2 * BUS_W;

	logic [BUS_W-1:0]       bus_s1;
	logic [LPR_W-1:0]       limprod_s2;
	logic signed [SQ_W-1:0] sqd_s2;
	logic signed [SQ_W-1:0] sqq_s2;
	logic [SQ_W-1:0]        mag_s3;
	logic [LSQ_W-1:0]       limsq_s3;

	// bus capture at item transfer
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bus_s1 <= bus_voltage;
		end
	end

	// limit product and squares of the previous outputs
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			limprod_s2 <= bus_s1 * max_modulation;
			sqd_s2     <= last_d * last_d;
			sqq_s2     <= last_q * last_q;
		end
	end

	assign lim = limprod_s2[LPR_W-1:dqpi_pkg::MOD_FRAC];

	// limit squared and magnitude sum
	always_ff @(posedge clk) begin
		if (ctrl.sqr) begin
			limsq_s3 <= lim * lim;
			mag_s3   <= $unsigned(sqd_s2) + $unsigned(sqq_s2);
		end
	end

	// vector at or over the limit
	assign back = (mag_s3 >= SQ_W'(limsq_s3));

endmodule

`default_nettype wire

[rtl/dq_current_pi_controller_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dq_current_pi_controller_top
// d and q current PI regulators with magnitude based anti-windup.
// ----------------------------------------------------------------------------
// Usage:
//  Items come in on item_valid/item_ready with kind, set points, measured
//  currents and bus voltage; results leave on result_valid/result_ready with
//  drive_d, drive_q and backing_off. Gains and the modulation ratio are set
//  through the APB port (byte addresses 0, 4, 8); pready is always high.
//  The result register is loaded at the end of the output step, which comes
//  after the products, limit square and integrator update steps.
//  Each item passes through the steps of the sequencer in order: products,
//  limit square and magnitude sum, integrator update, output clamp. The
//  limit square depends on the limit product, which sets the chain length.
//  A new item is taken during the output step of the last one, so items overlap.
//  Reset: integrators and previous outputs are zero, both gains zero and the
//  modulation ratio 37837.
//  Stall: while a result waits untaken, the next item holds at its output
//  step and no further item is accepted until the result register frees.
// ----------------------------------------------------------------------------
module dq_current_pi_controller_top #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire logic [dqpi_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [dqpi_pkg::DATA_W-1:0]     pwdata,
	output logic [dqpi_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	// input items
	input  wire                                  item_valid,
	output logic                                 item_ready,
	input  wire                                  kind,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  target_d,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  target_q,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  measured_d,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  measured_q,
	input  wire logic [SAMPLE_WIDTH-2:0]         bus_voltage,
	// results
	output logic                                 result_valid,
	input  wire                                  result_ready,
	output logic signed [SAMPLE_WIDTH-1:0]       drive_d,
	output logic signed [SAMPLE_WIDTH-1:0]       drive_q,
	output logic                                 backing_off
);

	localparam int GW = dqpi_pkg::GAIN_W;

	logic [GW-1:0]     prop_gain_q;
	logic [GW-1:0]     integ_gain_q;
	logic [GW-1:0]     max_mod_q;
	logic              kind_q;
	logic              result_valid_q;
	logic              backing_off_q;
	dqpi_pkg::state_t  state_q;
	dqpi_pkg::state_t  state_next;
	dqpi_pkg::ctrl_t   ctrl;
	logic              slot_free;
	logic              accept;
	logic              cfg_wr;
	logic [1:0]        reg_idx;
	logic [SAMPLE_WIDTH-2:0] lim;
	logic              back;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[dqpi_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			max_mod_q    <= dqpi_pkg::MOD_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				dqpi_pkg::REG_PROP_GAIN:  prop_gain_q  <= pwdata[GW-1:0];
				dqpi_pkg::REG_INTEG_GAIN: integ_gain_q <= pwdata[GW-1:0];
				dqpi_pkg::REG_MAX_MOD:    max_mod_q    <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			dqpi_pkg::REG_PROP_GAIN:  prdata = dqpi_pkg::DATA_W'(prop_gain_q);
			dqpi_pkg::REG_INTEG_GAIN: prdata = dqpi_pkg::DATA_W'(integ_gain_q);
			dqpi_pkg::REG_MAX_MOD:    prdata = dqpi_pkg::DATA_W'(max_mod_q);
			default:                  prdata = '0;
		endcase
	end

	// handshake
	assign slot_free = !result_valid_q || result_ready;
	assign accept    = item_valid && item_ready;

	// sequencer next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			dqpi_pkg::ST_IDLE: if (accept) state_next = dqpi_pkg::ST_MUL;
			dqpi_pkg::ST_MUL:  state_next = dqpi_pkg::ST_SQR;
			dqpi_pkg::ST_SQR:  state_next = dqpi_pkg::ST_UPD;
			dqpi_pkg::ST_UPD:  state_next = dqpi_pkg::ST_OUT;
			dqpi_pkg::ST_OUT: begin
				if (slot_free) begin
					state_next = accept ? dqpi_pkg::ST_MUL : dqpi_pkg::ST_IDLE;
				end
			end
			default: state_next = dqpi_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_ready = 1'b0;
		ctrl       = '0;
		ctrl.clr   = kind_q;
		case (state_q)
			dqpi_pkg::ST_IDLE: item_ready = 1'b1;
			dqpi_pkg::ST_MUL:  ctrl.mul = 1'b1;
			dqpi_pkg::ST_SQR:  ctrl.sqr = 1'b1;
			dqpi_pkg::ST_UPD:  ctrl.upd = 1'b1;
			dqpi_pkg::ST_OUT: begin
				item_ready = slot_free;
				ctrl.fin   = slot_free;
			end
			default: ;
		endcase
		ctrl.load = item_valid && item_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// item kind of the item in flight
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			kind_q <= kind;
		end
	end

	// result register control and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			backing_off_q  <= 1'b0;
		end else begin
			if (ctrl.fin) begin
				result_valid_q <= 1'b1;
				backing_off_q  <= (kind_q == dqpi_pkg::KIND_CLEAR) ? 1'b0 : back;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign backing_off  = backing_off_q;

	// axis lanes
	dqpi_lane #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_lane_d (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.target     (target_d),
		.measured   (measured_d),
		.prop_gain  (prop_gain_q),
		.integ_gain (integ_gain_q),
		.back       (back),
		.lim        (lim),
		.drive      (drive_d)
	);

	dqpi_lane #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_lane_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.target     (target_q),
		.measured   (measured_q),
		.prop_gain  (prop_gain_q),
		.integ_gain (integ_gain_q),
		.back       (back),
		.lim        (lim),
		.drive      (drive_q)
	);

	// limit and magnitude merge
	dqpi_limit #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_limit (
		.clk            (clk),
		.ctrl           (ctrl),
		.bus_voltage    (bus_voltage),
		.max_modulation (max_mod_q),
		.last_d         (drive_d),
		.last_q         (drive_q),
		.lim            (lim),
		.back           (back)
	);

	// checks
	a_fin_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin |=> result_valid)
		else $error("result not flagged after output step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == dqpi_pkg::ST_MUL)
		else $error("transfer did not start the sequence");

	a_upd_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dqpi_pkg::ST_UPD |=> state_q == dqpi_pkg::ST_OUT)
		else $error("update step not followed by output step");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin && kind_q |=> !backing_off && drive_d == '0 && drive_q == '0)
		else $error("clear item gave a nonzero result");

	a_no_fin_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin |-> slot_free)
		else $error("result overwritten while waiting");

endmodule

`default_nettype wire

[bench/tb_dq_current_pi_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dq_current_pi_controller_top
// Self-checking bench for the dq current PI controller: a scoreboard predicts
// every drive vector from its own copy of gains, integrators and previous
// outputs, while random stalls on both channels exercise the handshakes.
// ----------------------------------------------------------------------------

// one expected or observed drive vector
typedef struct {
	logic signed [15:0] d;
	logic signed [15:0] q;
	logic               back;
} drive_t;

// predicts the controller and checks its drive vectors in order
class drive_scoreboard;
	longint prop_gain, integ_gain, max_mod;
	longint acc_d, acc_q, last_d, last_q;
	drive_t pending[$];
	int errors, updates, clears, backoffs, writes;

	function new();
		prop_gain  = 0;
		integ_gain = 0;
		max_mod    = longint'(dqpi_pkg::MOD_RESET);
		acc_d      = 0;
		acc_q      = 0;
		last_d     = 0;
		last_q     = 0;
		errors     = 0;
		updates    = 0;
		clears     = 0;
		backoffs   = 0;
		writes     = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [15:0] val);
		writes++;
		case (idx)
			dqpi_pkg::REG_PROP_GAIN:  prop_gain  = longint'(val);
			dqpi_pkg::REG_INTEG_GAIN: integ_gain = longint'(val);
			dqpi_pkg::REG_MAX_MOD:    max_mod    = longint'(val);
			default: ;
		endcase
	endfunction

	// integrator decay, magnitude truncated toward zero
	function longint shrink(longint a);
		longint mag;
		mag = (a < 0) ? -a : a;
		mag = (mag * longint'(dqpi_pkg::DECAY_NUM)) >>> dqpi_pkg::DECAY_FRAC;
		return (a < 0) ? -mag : mag;
	endfunction

	function longint sat32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function longint clamp_lim(longint x, longint lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	// one accepted item: advance the predicted state, queue the drive vector
	function void note_item(logic k, logic signed [15:0] td, logic signed [15:0] tq,
			logic signed [15:0] md, logic signed [15:0] mq, logic [14:0] bus);
		drive_t exp_r;
		longint ed, eq, lim, dd, dq;
		exp_r.back = 1'b0;
		if (k == dqpi_pkg::KIND_CLEAR) begin
			acc_d  = 0;
			acc_q  = 0;
			last_d = 0;
			last_q = 0;
			dd     = 0;
			dq     = 0;
			clears++;
		end else begin
			ed  = longint'(td) - longint'(md);
			eq  = longint'(tq) - longint'(mq);
			lim = (longint'(bus) * max_mod) >>> dqpi_pkg::MOD_FRAC;
			// anti-windup: previous vector at or past the limit
			if (last_d * last_d + last_q * last_q >= lim * lim) begin
				exp_r.back = 1'b1;
				acc_d = shrink(acc_d);
				acc_q = shrink(acc_q);
				backoffs++;
			end else begin
				acc_d = sat32(acc_d + integ_gain * ed);
				acc_q = sat32(acc_q + integ_gain * eq);
			end
			dd = clamp_lim((prop_gain * ed + acc_d) >>> 8, lim);
			dq = clamp_lim((prop_gain * eq + acc_q) >>> 8, lim);
			last_d = dd;
			last_q = dq;
			updates++;
		end
		exp_r.d = dd[15:0];
		exp_r.q = dq[15:0];
		pending.push_back(exp_r);
	endfunction

	function void check_drive(logic signed [15:0] got_d, logic signed [15:0] got_q,
			logic got_b);
		drive_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t unexpected result transfer: d %0d q %0d back %0b",
				$time, got_d, got_q, got_b);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got_d !== exp_r.d) begin
			$display("%0t drive_d mismatch: expected %0d, got %0d", $time, exp_r.d, got_d);
			errors++;
		end
		if (got_q !== exp_r.q) begin
			$display("%0t drive_q mismatch: expected %0d, got %0d", $time, exp_r.q, got_q);
			errors++;
		end
		if (got_b !== exp_r.back) begin
			$display("%0t backing_off mismatch: expected %0b, got %0b",
				$time, exp_r.back, got_b);
			errors++;
		end
	endfunction
endclass

module tb_dq_current_pi_controller_top;

	localparam int CYCLE_LIMIT = 1000000;
	localparam logic signed [15:0] S_MAX = 16'sh7FFF;
	localparam logic signed [15:0] S_MIN = 16'sh8000;
	localparam logic [14:0]        BUS_MAX = 15'h7FFF;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                                psel    = 1'b0;
	logic                                penable = 1'b0;
	logic                                pwrite  = 1'b0;
	logic [dqpi_pkg::ADDR_W-1:0]         paddr   = '0;
	logic [dqpi_pkg::DATA_W-1:0]         pwdata  = '0;
	logic [dqpi_pkg::DATA_W-1:0]         prdata;
	logic                                pready;

	logic                                item_valid  = 1'b0;
	logic                                item_ready;
	logic                                kind        = 1'b0;
	logic signed [15:0]                  target_d    = '0;
	logic signed [15:0]                  target_q    = '0;
	logic signed [15:0]                  measured_d  = '0;
	logic signed [15:0]                  measured_q  = '0;
	logic [14:0]                         bus_voltage = '0;

	logic                                result_valid;
	logic                                result_ready = 1'b0;
	logic signed [15:0]                  drive_d;
	logic signed [15:0]                  drive_q;
	logic                                backing_off;

	drive_scoreboard sb;
	bit steady       = 1'b0;   // no random idling on either side while set
	int hold_request = 0;      // long receiver hold-off, picked up by the sink
	int cycles       = 0;

	dq_current_pi_controller_top #(
		.SAMPLE_WIDTH   (16),
		.GAIN_FRAC_BITS (8)
	) dut (.*);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("dq_current_pi_controller_top regression: fail");
		$finish;
	end

	// idle length: mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int pick_gap();
		if (steady || $urandom_range(0, 1) == 0)
			return 0;
		return idle_len();
	endfunction

	function automatic logic signed [15:0] clip16(int v);
		if (v > 32767)
			return S_MAX;
		if (v < -32768)
			return S_MIN;
		return 16'(v);
	endfunction

	function automatic int spread(int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	function automatic logic signed [15:0] rnd16();
		return 16'($urandom());
	endfunction

	function automatic logic [14:0] pick_bus();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 75)
			return 15'($urandom_range(8000, 32767));
		return 15'($urandom_range(0, 32767));
	endfunction

	// result sink: random stalls, long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				sb.check_drive(drive_d, drive_q, backing_off);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 30) begin
				stall_left = idle_len() - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// register write: setup cycle, access cycle, then a return to idle
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] mod);
		write_reg(dqpi_pkg::REG_PROP_GAIN, kp);
		write_reg(dqpi_pkg::REG_INTEG_GAIN, ki);
		write_reg(dqpi_pkg::REG_MAX_MOD, mod);
	endtask

	// one item transfer, then a random gap
	task automatic send_item(logic k, logic signed [15:0] td, logic signed [15:0] tq,
			logic signed [15:0] md, logic signed [15:0] mq, logic [14:0] bus);
		int gap;
		item_valid  <= 1'b1;
		kind        <= k;
		target_d    <= td;
		target_q    <= tq;
		measured_d  <= md;
		measured_q  <= mq;
		bus_voltage <= bus;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_item(k, td, tq, md, mq, bus);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_update(logic signed [15:0] td, logic signed [15:0] tq,
			logic signed [15:0] md, logic signed [15:0] mq, logic [14:0] bus);
		send_item(dqpi_pkg::KIND_UPDATE, td, tq, md, mq, bus);
	endtask

	task automatic send_clear();
		send_item(dqpi_pkg::KIND_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), 15'($urandom()));
	endtask

	// wait until every drive vector is back, then let the pipeline settle
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// tracking runs with random content, mixed with noise bursts
	task automatic random_phase(int count);
		int sent, run_len, mag, i, n;
		int td, tq, md, mq;
		logic [14:0] bus;
		sent = 0;
		while (sent < count) begin
			steady = ($urandom_range(0, 99) < 15);
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 1) == 1) begin
					send_clear();
					sent++;
				end
				mag = 1 << $urandom_range(2, 15);
				td  = spread(mag);
				tq  = spread(mag);
				md  = td + spread(mag);
				mq  = tq + spread(mag);
				bus = pick_bus();
				run_len = $urandom_range(5, 30);
				for (i = 0; i < run_len; i++) begin
					send_update(clip16(td), clip16(tq), clip16(md), clip16(mq), bus);
					sent++;
					// measured current closes in on the set point, with noise
					md = md + (td - md) / 4 + spread(mag / 16 + 1);
					mq = mq + (tq - mq) / 4 + spread(mag / 16 + 1);
					if ($urandom_range(0, 99) < 8) begin
						td = spread(mag);
						tq = spread(mag);
					end
					if ($urandom_range(0, 99) < 5)
						bus = pick_bus();
				end
			end else begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++) begin
					send_item(($urandom_range(0, 9) == 0) ? dqpi_pkg::KIND_CLEAR
						: dqpi_pkg::KIND_UPDATE, rnd16(), rnd16(), rnd16(), rnd16(),
						15'($urandom()));
					sent++;
				end
			end
		end
		steady = 1'b0;
	endtask

	// main sequence
	initial begin
		int i;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: zero outputs, zero limit, clear
		send_update(S_MAX, S_MIN, S_MIN, S_MAX, BUS_MAX);
		send_update(S_MAX, S_MIN, S_MIN, S_MAX, '0);
		send_clear();
		wait_idle();

		// full gains: integrator saturation, clamp, back-off and decay
		set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_update(S_MAX, S_MIN, S_MIN, S_MAX, BUS_MAX);
		send_update(S_MAX, S_MIN, S_MIN, S_MAX, BUS_MAX);
		send_update(S_MAX, S_MIN, S_MIN, S_MAX, BUS_MAX);
		send_clear();
		send_update(S_MIN, S_MAX, S_MAX, S_MIN, BUS_MAX);
		send_update(S_MIN, S_MAX, S_MAX, S_MIN, '0);
		send_clear();
		wait_idle();

		// unit gains: floor rounding of negatives, decay of small values to zero
		set_gains(16'd1, 16'd1, 16'hFFFF);
		send_update(16'sd0, 16'sd1, 16'sd1, 16'sd0, BUS_MAX);
		send_update(16'sd0, 16'sd1, 16'sd1, 16'sd0, BUS_MAX);
		for (i = 0; i < 3; i++)
			send_update(16'sd0, 16'sd1, 16'sd1, 16'sd0, '0);
		send_update(16'sd100, 16'sd100, 16'sd100, 16'sd100, 15'd1);
		send_clear();
		wait_idle();

		// random phases over several gain settings
		set_gains(16'd256, 16'd32, dqpi_pkg::MOD_RESET);
		random_phase(140);
		wait_idle();
		set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_phase(140);
		wait_idle();
		set_gains(16'd0, 16'd0, 16'd0);
		random_phase(140);
		wait_idle();

		// receiver holds off while items keep coming, so the input stalls
		set_gains(16'd64, 16'd4, 16'hFFFF);
		hold_request = 300;
		steady = 1'b1;
		for (i = 0; i < 20; i++)
			send_update(rnd16(), rnd16(), rnd16(), rnd16(), pick_bus());
		steady = 1'b0;
		random_phase(120);
		wait_idle();

		set_gains(16'd1024, 16'd1, 16'd20000);
		random_phase(140);
		wait_idle();
		set_gains(16'd0, 16'hFFFF, dqpi_pkg::MOD_RESET);
		random_phase(140);
		wait_idle();
		set_gains(16'hFFFF, 16'd0, 16'd1);
		random_phase(140);
		wait_idle();
		set_gains(16'd200, 16'd10, 16'd50000);
		random_phase(140);
		wait_idle();

		// final check: nothing may be left outstanding
		if (sb.pending.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, sb.pending.size());
			sb.errors++;
		end
		$display("covered %0d updates (%0d with back-off) and %0d clears", sb.updates,
			sb.backoffs, sb.clears);
		$display("over %0d register writes in %0d cycles, %0d errors", sb.writes, cycles,
			sb.errors);
		if (sb.errors == 0)
			$display("dq_current_pi_controller_top regression: pass");
		else
			$display("dq_current_pi_controller_top regression: fail");
		$finish;
	end

endmodule
